### hdl/steering_command_conditioner_macros.svh
// ----------------------------------------------------------------------------
// steering command conditioner assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef STEERING_COMMAND_CONDITIONER_MACROS_SVH
`define STEERING_COMMAND_CONDITIONER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk_i, off during reset
`define SCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("steering command conditioner check failed");
// next-cycle implication, sampled on clk_i, off during reset
`define SCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("steering command conditioner check failed");
`else
`define SCC_ASSERT_NOW(lbl, ante, cons)
`define SCC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// shared types and constants of the steering command conditioner
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int unsigned STATE_FRAC_BITS_DEF = 8;

  localparam int unsigned CMD_W      = 11;
  localparam int unsigned DEADZONE_W = 10;
  localparam int unsigned COEFF_W    = 16;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned SMOOTH_W   = 19;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic signed [CMD_W-1:0] CMD_POS_FULL = 11'sd1000;
  localparam logic signed [CMD_W-1:0] CMD_NEG_FULL = -11'sd1000;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST = 12'd256;
  localparam logic [PULSE_W-1:0] PMIN_RST = 12'd1000;
  localparam logic [PULSE_W-1:0] PMAX_RST = 12'd2000;
  localparam logic [PULSE_W-1:0] PMID_RST = 12'd1500;

  // offset divisor 2000 * 2^(frac+8) = 125 * 2^(frac+8+4)
  localparam int unsigned GAIN_FRAC_BITS = 8;
  localparam int unsigned DIV_POW2       = 4;
  localparam int unsigned DIV_ODD        = 125;

  // floor(y/125) = (y * ceil(2^30/125)) >> 30 for y below 2^23
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_W     = 24;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_VAL);

  localparam int unsigned Y_W    = 24;  // scaled magnitude before the reciprocal
  localparam int unsigned MB_W   = 25;  // second operand of the shared multiplier
  localparam int unsigned QUOT_W = 15;  // offset magnitude, at most 32752
  localparam int unsigned PSUM_W = 17;  // mid plus signed offset

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE,
    CFG_INVERT,
    CFG_COEFF,
    CFG_GAIN,
    CFG_PMIN,
    CFG_PMAX,
    CFG_PMID
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_GAIN,
    ST_SCALE,
    ST_ABS,
    ST_DIV,
    ST_FINISH
  } seq_state_e;

endpackage

### hdl/scc_mul.sv
// ----------------------------------------------------------------------------
// scc_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module scc_mul import scc_pkg::*; #(
  parameter int unsigned A_W = MB_W,
  parameter int unsigned B_W = MB_W
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [A_W-1:0]     a_i,
  input  logic signed [B_W-1:0]     b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

### hdl/steering_command_conditioner.sv
// ----------------------------------------------------------------------------
// steering_command_conditioner
// deadzone, invert, exponential smoothing and servo pulse scaling
// ----------------------------------------------------------------------------
// Each steering command beat is saturated to +/-1000, zeroed below the
// deadzone, optionally negated, and fed through a first-order smoother whose
// state carries STATE_FRAC_BITS fraction bits. The new state is scaled by gain
// and pulse span into a signed offset around the mid pulse width, truncated
// toward zero and clamped to [min,max]. Each item takes the accept cycle
// plus six sequencer steps; the result is offered as the sequencer returns
// to idle, where the next command is taken. The steps are set by
// the one shared multiplier, which runs four products per item (smoother
// blend, gain times span, state times that, reciprocal for the divide by
// 2000). A finished result sits in the output register, so a new command is
// accepted while the previous result still waits; only if that result is
// still held when the next one finishes does the sequencer pause.
// Configuration is a plain write port taken whenever cfg_we_i is high;
// indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
`include "steering_command_conditioner_macros.svh"

module steering_command_conditioner import scc_pkg::*; #(
  parameter int unsigned STATE_FRAC_BITS = STATE_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [CMD_W-1:0]    steer_cmd_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [PULSE_W-1:0]         pulse_us_o,
  output logic signed [SMOOTH_W-1:0] smoothed_cmd_o,
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i
);

  // smoother state width: |state| <= 1000 * 2^frac
  localparam int unsigned SW        = STATE_FRAC_BITS + CMD_W;
  localparam int unsigned DIFF_W    = SW + 1;
  localparam int unsigned MA_W      = (DIFF_W > MB_W) ? DIFF_W : MB_W;
  localparam int unsigned P_W       = MA_W + MB_W;
  localparam int unsigned NUM_SHIFT = STATE_FRAC_BITS + GAIN_FRAC_BITS + DIV_POW2;
  localparam int unsigned SPAN_W    = PULSE_W + 1;

  // configuration registers
  logic [DEADZONE_W-1:0] deadzone_q;
  logic                  invert_q;
  logic [COEFF_W-1:0]    coeff_q;
  logic [GAIN_W-1:0]     gain_q;
  logic [PULSE_W-1:0]    pmin_q;
  logic [PULSE_W-1:0]    pmax_q;
  logic [PULSE_W-1:0]    pmid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= '0;
      invert_q   <= 1'b0;
      coeff_q    <= '0;
      gain_q     <= GAIN_RST;
      pmin_q     <= PMIN_RST;
      pmax_q     <= PMAX_RST;
      pmid_q     <= PMID_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DEADZONE: deadzone_q <= cfg_wdata_i[DEADZONE_W-1:0];
        CFG_INVERT:   invert_q   <= cfg_wdata_i[0];
        CFG_COEFF:    coeff_q    <= cfg_wdata_i[COEFF_W-1:0];
        CFG_GAIN:     gain_q     <= cfg_wdata_i[GAIN_W-1:0];
        CFG_PMIN:     pmin_q     <= cfg_wdata_i[PULSE_W-1:0];
        CFG_PMAX:     pmax_q     <= cfg_wdata_i[PULSE_W-1:0];
        CFG_PMID:     pmid_q     <= cfg_wdata_i[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // command conditioning on the incoming beat
  logic signed [CMD_W-1:0]  cmd_sat;
  logic signed [CMD_W-1:0]  cmd_abs;
  logic signed [CMD_W-1:0]  cmd_dz;
  logic signed [CMD_W-1:0]  cmd_cond;

  always_comb begin
    if (steer_cmd_i > CMD_POS_FULL) begin
      cmd_sat = CMD_POS_FULL;
    end else if (steer_cmd_i < CMD_NEG_FULL) begin
      cmd_sat = CMD_NEG_FULL;
    end else begin
      cmd_sat = steer_cmd_i;
    end
    cmd_abs  = cmd_sat[CMD_W-1] ? -cmd_sat : cmd_sat;
    cmd_dz   = (cmd_abs[DEADZONE_W-1:0] < deadzone_q) ? '0 : cmd_sat;
    cmd_cond = invert_q ? -cmd_dz : cmd_dz;
  end

  // sequencer and datapath registers
  seq_state_e               seq_q, seq_d;
  logic signed [CMD_W-1:0]  cmd_q;
  logic signed [SW-1:0]     smooth_q;
  logic [Y_W-1:0]           y_q;
  logic                     neg_q;
  logic                     out_valid_q;
  logic [PULSE_W-1:0]       pulse_q;
  logic signed [SMOOTH_W-1:0] smoothed_q;

  logic                     out_free;
  logic                     in_take;
  logic                     mul_en;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [P_W-1:0]    prod;

  logic signed [SW-1:0]     target;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SPAN_W-1:0] span;
  logic signed [P_W-1:0]    blend_shift;
  logic signed [SW-1:0]     smooth_d;
  logic [P_W-1:0]           num_abs;
  logic [Y_W-1:0]           y_d;
  logic [QUOT_W-1:0]        quot;
  logic signed [PSUM_W-1:0] offset;
  logic signed [PSUM_W-1:0] pulse_sum;
  logic [PULSE_W-1:0]       pulse_d;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_take  = in_valid_i && in_ready_o;

  // smoother: new = floor(a*(old - target) / 2^16) + target
  assign target      = $signed(SW'(cmd_q)) <<< STATE_FRAC_BITS;
  assign diff        = DIFF_W'(smooth_q) - DIFF_W'(target);
  assign span        = $signed({1'b0, pmax_q}) - $signed({1'b0, pmin_q});
  assign blend_shift = prod >>> COEFF_W;
  assign smooth_d    = SW'(blend_shift) + target;

  // offset magnitude, then divide by 2000 * 2^(frac+8) via shift and reciprocal
  assign num_abs = prod[P_W-1] ? P_W'(-prod) : P_W'(prod);
  assign y_d     = Y_W'(num_abs >> NUM_SHIFT);
  assign quot    = QUOT_W'(prod >> RECIP_SHIFT);

  always_comb begin
    offset    = neg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    pulse_sum = $signed({5'b00000, pmid_q}) + offset;
    if (pulse_sum < $signed({5'b00000, pmin_q})) begin
      pulse_d = pmin_q;
    end else if (pulse_sum > $signed({5'b00000, pmax_q})) begin
      pulse_d = pmax_q;
    end else begin
      pulse_d = PULSE_W'(pulse_sum);
    end
  end

  // next state and shared multiplier operand select
  always_comb begin
    seq_d      = seq_q;
    in_ready_o = 1'b0;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (seq_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          seq_d = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        mul_en = 1'b1;
        mul_a  = MA_W'(diff);
        mul_b  = MB_W'($signed({1'b0, coeff_q}));
        seq_d  = ST_GAIN;
      end
      ST_GAIN: begin
        mul_en = 1'b1;
        mul_a  = MA_W'(span);
        mul_b  = MB_W'($signed({1'b0, gain_q}));
        seq_d  = ST_SCALE;
      end
      ST_SCALE: begin
        mul_en = 1'b1;
        mul_a  = MA_W'(smooth_q);
        mul_b  = prod[MB_W-1:0];
        seq_d  = ST_ABS;
      end
      ST_ABS: begin
        seq_d = ST_DIV;
      end
      ST_DIV: begin
        mul_en = 1'b1;
        mul_a  = MA_W'($signed({1'b0, RECIP_MULT}));
        mul_b  = $signed({1'b0, y_q});
        seq_d  = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (out_free) begin
          seq_d = ST_IDLE;
        end
      end
      default: begin
        seq_d = ST_IDLE;
      end
    endcase
  end

  scc_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= ST_IDLE;
      smooth_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      // smoother state takes the blended value once per item
      if (seq_q == ST_GAIN) begin
        smooth_q <= smooth_d;
      end
      if ((seq_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_cond;
    end
    if (seq_q == ST_ABS) begin
      y_q   <= y_d;
      neg_q <= prod[P_W-1];
    end
    if ((seq_q == ST_FINISH) && out_free) begin
      pulse_q    <= pulse_d;
      smoothed_q <= SMOOTH_W'(smooth_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pulse_us_o     = pulse_q;
  assign smoothed_cmd_o = smoothed_q;

  // an accepted beat always starts the smoother step
  `SCC_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, seq_q == ST_SMOOTH)
  // smoother state moves only in its update step
  `SCC_ASSERT_NEXT(a_state_hold, seq_q != ST_GAIN, $stable(smooth_q))
  // scaled magnitude stays inside the reciprocal's exact range
  `SCC_ASSERT_NOW(a_recip_range, seq_q == ST_DIV, y_q[Y_W-1:Y_W-2] == 2'b00)
  // an ordered pulse window bounds the offered pulse
  `SCC_ASSERT_NOW(a_pulse_window, out_valid_o && (pmin_q <= pmax_q), (pulse_us_o >= pmin_q) && (pulse_us_o <= pmax_q))

endmodule
